/* src/gfmi_pkg.sv */
// Shared types, constants and the GF(2^8) multiply function for the
// multiply/inverse unit. No dependencies.
package gfmi_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned NumSteps   = 13;  // one entry step plus twelve chain steps
   localparam logic [ByteWidth-1:0] PolyReset = 8'h1B;

   typedef enum logic [1:0] {
      MODE_ADD = 2'd0,
      MODE_MUL = 2'd1,
      MODE_INV = 2'd2
   } mode_type;

   typedef enum logic {
      STEP_SQUARE = 1'b0,
      STEP_MUL_A  = 1'b1
   } step_type;

   typedef struct packed {
      mode_type             mode;
      logic [ByteWidth-1:0] a;
      logic [ByteWidth-1:0] r;
   } item_type;

   // Carry-less product of two bytes reduced by x^8 + poly_low.
   function automatic logic [ByteWidth-1:0] gf_mul(
      input logic [ByteWidth-1:0] x_in,
      input logic [ByteWidth-1:0] y_in,
      input logic [ByteWidth-1:0] poly_low
   );
      logic [ByteWidth-1:0] x;
      logic [ByteWidth-1:0] acc;
      logic                 carry;
      x   = x_in;
      acc = '0;
      for (int k = 0; k < ByteWidth; k++) begin
         if (y_in[k]) begin
            acc = acc ^ x;
         end
         carry = x[ByteWidth-1];
         x     = {x[ByteWidth-2:0], 1'b0};
         if (carry) begin
            x = x ^ poly_low;
         end
      end
      return acc;
   endfunction

endpackage

/* src/gf256_multiply_inverse_unit.sv */
// Top level of the GF(2^8) add/multiply/inverse unit: polynomial register,
// entry stage and twelve chain stages. Depends on gfmi_pkg, gfmi_entry, gfmi_step.
//
//   channel | ports                                  | direction
//   --------+----------------------------------------+----------
//   request | req_valid, req_stall, req_mode, req_operand_a/b | in
//   result  | rsp_valid, rsp_stall, rsp_result       | out
//   config  | csr_write_enable, csr_write_data       | in
//
// At most one GF multiply per stage; a new transaction enters every cycle
// unless a held result stalls the pipeline. The last stage register is the
// output register. Reset clears all stage valid bits and loads polynomial 0x1B.
// A stalled result freezes the whole pipeline; req_stall follows it directly.
module gf256_multiply_inverse_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_mode,
   input  logic [gfmi_pkg::ByteWidth-1:0] req_operand_a,
   input  logic [gfmi_pkg::ByteWidth-1:0] req_operand_b,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [gfmi_pkg::ByteWidth-1:0] rsp_result,
   input  logic                          csr_write_enable,
   input  logic [gfmi_pkg::ByteWidth-1:0] csr_write_data
);
   import gfmi_pkg::*;

   logic [ByteWidth-1:0] poly_ff;
   logic                 advance;
   logic                 stage_valid [NumSteps];
   item_type             stage_item  [NumSteps];

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff <= PolyReset;
      end else if (csr_write_enable) begin
         poly_ff <= csr_write_data;
      end
   end

   // Advance everything unless a finished result is held.
   assign advance   = !(stage_valid[NumSteps-1] && rsp_stall);
   assign req_stall = !advance;

   gfmi_entry u_entry (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_mode   (req_mode),
      .in_a      (req_operand_a),
      .in_b      (req_operand_b),
      .poly      (poly_ff),
      .out_valid (stage_valid[0]),
      .out_item  (stage_item[0])
   );

   for (genvar i = 1; i < NumSteps; i++) begin : g_step
      gfmi_step u_step (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .kind      ((i % 2 == 1) ? STEP_MUL_A : STEP_SQUARE),
         .poly      (poly_ff),
         .in_valid  (stage_valid[i-1]),
         .in_item   (stage_item[i-1]),
         .out_valid (stage_valid[i]),
         .out_item  (stage_item[i])
      );
   end

   assign rsp_valid  = stage_valid[NumSteps-1];
   assign rsp_result = stage_item[NumSteps-1].r;

endmodule

/* src/gfmi_entry.sv */
// First pipeline stage: decodes the operation and does add, multiply or the
// first square of the inverse chain. Depends on gfmi_pkg.
module gfmi_entry (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic [1:0]                    in_mode,
   input  logic [gfmi_pkg::ByteWidth-1:0] in_a,
   input  logic [gfmi_pkg::ByteWidth-1:0] in_b,
   input  logic [gfmi_pkg::ByteWidth-1:0] poly,
   output logic                          out_valid,
   output gfmi_pkg::item_type            out_item
);
   import gfmi_pkg::*;

   logic     valid_ff;
   item_type item_ff;
   item_type item_in;

   always_comb begin
      item_in.mode = mode_type'(in_mode);
      item_in.a    = in_a;
      case (in_mode)
         MODE_ADD: item_in.r = in_a ^ in_b;
         MODE_MUL: item_in.r = gf_mul(in_a, in_b, poly);
         MODE_INV: item_in.r = gf_mul(in_a, in_a, poly);
         default:  item_in.r = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

/* src/gfmi_step.sv */
// One stage of the inverse chain: square the running value or multiply it
// by the operand; other operations pass through. Depends on gfmi_pkg.
module gfmi_step (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  gfmi_pkg::step_type            kind,
   input  logic [gfmi_pkg::ByteWidth-1:0] poly,
   input  logic                          in_valid,
   input  gfmi_pkg::item_type            in_item,
   output logic                          out_valid,
   output gfmi_pkg::item_type            out_item
);
   import gfmi_pkg::*;

   logic                 valid_ff;
   item_type             item_ff;
   item_type             item_in;
   logic [ByteWidth-1:0] factor;

   always_comb begin
      factor  = (kind == STEP_SQUARE) ? in_item.r : in_item.a;
      item_in = in_item;
      if (in_item.mode == MODE_INV) begin
         item_in.r = gf_mul(in_item.r, factor, poly);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

/* src/gfmi_checker.sv */
// Port-level checks for gf256_multiply_inverse_unit, attached by bind.
// Depends on gfmi_pkg.
module gfmi_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [gfmi_pkg::ByteWidth-1:0] rsp_result
);
   import gfmi_pkg::*;

   // A held result keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result))
      else $error("held result changed");

   // Input stalls exactly when the output transaction is held.
   assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("req_stall does not track the held output");

   // Reset empties the pipeline.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A result can only appear on a cycle the pipeline moved.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_stall))
      else $error("result appeared while frozen");

   // A stalled request stays offered until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid)
      else $error("request withdrawn while stalled");

endmodule

bind gf256_multiply_inverse_unit gfmi_checker u_gfmi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_result (rsp_result)
);

/* dv/gfmi_result_checker.sv */
// Checker for the GF(2^8) add/multiply/inverse unit: watches the request,
// result and register ports, predicts every result and compares in order.
// Depends on gfmi_pkg.
module gfmi_result_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [1:0]                     req_mode,
   input  logic [gfmi_pkg::ByteWidth-1:0] req_operand_a,
   input  logic [gfmi_pkg::ByteWidth-1:0] req_operand_b,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [gfmi_pkg::ByteWidth-1:0] rsp_result,
   input  logic                           csr_write_enable,
   input  logic [gfmi_pkg::ByteWidth-1:0] csr_write_data,
   output int                             fail_count,
   output int                             pending
);
   import gfmi_pkg::*;

   localparam int unsigned WideWidth   = 2 * ByteWidth - 1;
   localparam int unsigned InvRounds   = 6;
   localparam int unsigned ReportLimit = 10;

   typedef struct packed {
      logic [1:0]           mode;
      logic [ByteWidth-1:0] a;
      logic [ByteWidth-1:0] b;
      logic [ByteWidth-1:0] value;
   } outcome_type;

   logic [ByteWidth-1:0] poly_low = PolyReset;
   outcome_type          awaiting[$];
   int                   mismatches = 0;

   assign fail_count = mismatches;

   // Full carry-less product first, then fold the high bits back down.
   function automatic logic [ByteWidth-1:0] field_product(
      input logic [ByteWidth-1:0] x,
      input logic [ByteWidth-1:0] y,
      input logic [ByteWidth-1:0] low
   );
      logic [WideWidth-1:0] wide;
      logic [ByteWidth:0]   modulus;
      wide    = '0;
      modulus = {1'b1, low};
      for (int i = 0; i < ByteWidth; i++) begin
         if (y[i]) begin
            wide = wide ^ (WideWidth'(x) << i);
         end
      end
      for (int i = WideWidth - 1; i >= ByteWidth; i--) begin
         if (wide[i]) begin
            wide = wide ^ (WideWidth'(modulus) << (i - ByteWidth));
         end
      end
      return wide[ByteWidth-1:0];
   endfunction

   // a^254 by square-and-multiply; no irreducibility check on the polynomial
   function automatic logic [ByteWidth-1:0] field_inverse(
      input logic [ByteWidth-1:0] a,
      input logic [ByteWidth-1:0] low
   );
      logic [ByteWidth-1:0] r;
      if (a == '0) begin
         return '0;
      end
      r = a;
      for (int k = 0; k < InvRounds; k++) begin
         r = field_product(r, r, low);
         r = field_product(r, a, low);
      end
      return field_product(r, r, low);
   endfunction

   function automatic logic [ByteWidth-1:0] predict_result(
      input logic [1:0]           mode,
      input logic [ByteWidth-1:0] a,
      input logic [ByteWidth-1:0] b,
      input logic [ByteWidth-1:0] low
   );
      case (mode)
         MODE_ADD: return a ^ b;
         MODE_MUL: return field_product(a, b, low);
         MODE_INV: return field_inverse(a, low);
         default:  return '0;
      endcase
   endfunction

   always @(posedge clock) begin
      outcome_type head;
      outcome_type fresh;
      if (reset) begin
         poly_low <= PolyReset;
         awaiting.delete();
         pending  <= 0;
      end else begin
         if (csr_write_enable) begin
            poly_low <= csr_write_data;
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaiting.size() == 0) begin
               mismatches++;
               if (mismatches <= ReportLimit) begin
                  $display("error: result %02h with no transaction outstanding", rsp_result);
               end
            end else begin
               head = awaiting.pop_front();
               if (rsp_result !== head.value) begin
                  mismatches++;
                  if (mismatches <= ReportLimit) begin
                     $display("error: mode %0d a %02h b %02h poly %02h: expected %02h, got %02h",
                              head.mode, head.a, head.b, poly_low, head.value, rsp_result);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            fresh.mode  = req_mode;
            fresh.a     = req_operand_a;
            fresh.b     = req_operand_b;
            fresh.value = predict_result(req_mode, req_operand_a, req_operand_b, poly_low);
            awaiting.insert(awaiting.size(), fresh);
         end
         pending <= awaiting.size();
      end
   end

endmodule

/* dv/tb_gf256_multiply_inverse_unit.sv */
// Testbench top for gf256_multiply_inverse_unit: clock, reset, request and
// register stimulus, result-side stalls and the verdict.
// Depends on gfmi_pkg, the unit and gfmi_result_checker.
module tb_gf256_multiply_inverse_unit;
   import gfmi_pkg::*;

   localparam int unsigned ResetCycles   = 6;
   localparam int unsigned ItemsPerPhase = 250;
   localparam int unsigned LongHold      = 300;
   localparam int unsigned WatchdogLimit = 2000;
   localparam logic [1:0]  ModeUnused    = 2'd3;

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_stall;
   logic [1:0]           req_mode         = MODE_ADD;
   logic [ByteWidth-1:0] req_operand_a    = '0;
   logic [ByteWidth-1:0] req_operand_b    = '0;
   logic                 rsp_valid;
   logic                 rsp_stall        = 1'b0;
   logic [ByteWidth-1:0] rsp_result;
   logic                 csr_write_enable = 1'b0;
   logic [ByteWidth-1:0] csr_write_data   = '0;

   int                   fail_count;
   int                   pending;
   int                   phase_index = 0;
   int unsigned          send_calm   = 0;
   int unsigned          stall_left  = 0;
   int unsigned          rsp_calm    = 0;
   int unsigned          idle_cycles = 0;
   logic                 long_hold   = 1'b0;
   logic [ByteWidth-1:0] phase_polys[5] = '{8'h1D, 8'h00, 8'hFF, 8'h00, PolyReset};

   always #5 clock = ~clock;

   gf256_multiply_inverse_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_operand_a    (req_operand_a),
      .req_operand_b    (req_operand_b),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result       (rsp_result),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   gfmi_result_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_operand_a    (req_operand_a),
      .req_operand_b    (req_operand_b),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result       (rsp_result),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   // mostly short, now and then long
   function automatic int unsigned gap_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
   endfunction

   function automatic logic [ByteWidth-1:0] pick_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'h01 << $urandom_range(0, 7);
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [1:0] pick_mode();
      return ($urandom_range(0, 11) == 0) ? ModeUnused : 2'($urandom_range(0, 2));
   endfunction

   task automatic send_op(
      input logic [1:0]           mode,
      input logic [ByteWidth-1:0] a,
      input logic [ByteWidth-1:0] b
   );
      int unsigned gap;
      if (send_calm != 0) begin
         send_calm--;
         gap = 0;
      end else begin
         if ($urandom_range(0, 149) == 0) begin
            send_calm = $urandom_range(30, 120);
         end
         gap = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= mode;
      req_operand_a <= a;
      req_operand_b <= b;
      do @(posedge clock); while (req_stall);
   endtask

   // drop the request, wait out every outstanding transaction, then let the pipeline empty
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (2 * NumSteps) @(posedge clock);
   endtask

   task automatic write_polynomial(input logic [ByteWidth-1:0] low);
      csr_write_enable <= 1'b1;
      csr_write_data   <= low;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // result side: random stalls, calm stretches, and one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
         rsp_calm   <= 0;
      end else begin
         if (rsp_calm != 0) begin
            rsp_calm <= rsp_calm - 1;
         end else if ($urandom_range(0, 99) == 0) begin
            rsp_calm <= $urandom_range(40, 160);
         end
         if (long_hold) begin
            rsp_stall <= 1'b1;
         end else if (stall_left != 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
         end else if (rsp_calm == 0 && $urandom_range(0, 3) == 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= gap_len() - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // hold the result side long enough for the pipeline to back up
   initial begin
      wait (phase_index == 2);
      repeat (20) @(posedge clock);
      long_hold <= 1'b1;
      repeat (LongHold) @(posedge clock);
      long_hold <= 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      phase_polys[3] = 8'($urandom_range(1, 254));
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // directed: operand extremes, every mode, zero inverse, unused mode
      send_op(MODE_ADD, 8'h00, 8'h00);
      send_op(MODE_ADD, 8'hFF, 8'hFF);
      send_op(MODE_ADD, 8'hA5, 8'h5A);
      send_op(MODE_ADD, 8'h00, 8'hFF);
      send_op(MODE_MUL, 8'h00, 8'hB7);
      send_op(MODE_MUL, 8'h01, 8'hC3);
      send_op(MODE_MUL, 8'hFF, 8'hFF);
      send_op(MODE_MUL, 8'h80, 8'h02);
      send_op(MODE_MUL, 8'h80, 8'h80);
      send_op(MODE_MUL, 8'h57, 8'h83);
      send_op(MODE_INV, 8'h00, 8'hFF);
      send_op(MODE_INV, 8'h01, 8'h00);
      send_op(MODE_INV, 8'h02, 8'h00);
      send_op(MODE_INV, 8'hFF, 8'h00);
      send_op(MODE_INV, 8'h53, 8'hAA);
      send_op(ModeUnused, 8'hFF, 8'hFF);
      send_op(ModeUnused, 8'h00, 8'h00);

      // each phase runs under its own polynomial, reducible ones included
      foreach (phase_polys[p]) begin
         wait_until_drained();
         write_polynomial(phase_polys[p]);
         phase_index = p + 1;
         repeat (ItemsPerPhase) send_op(pick_mode(), pick_byte(), pick_byte());
      end
      wait_until_drained();

      if (fail_count == 0 && pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* gf256_multiply_inverse_unit.f */
src/gfmi_pkg.sv
src/gfmi_entry.sv
src/gfmi_step.sv
src/gf256_multiply_inverse_unit.sv
src/gfmi_checker.sv
dv/gfmi_result_checker.sv
dv/tb_gf256_multiply_inverse_unit.sv
